/* rtl/core/afc_pkg.sv */
// Shared types, constants and helper functions for the angle frame check core.
// No dependencies; every other file in rtl/core uses this package by scoped names.
package afc_pkg;

  // CORDIC depth and table length
  localparam int CORDIC_STEPS = 16;
  localparam int TABLE_LEN    = 24;
  localparam int NSTEPS       = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;

  // datapath widths
  localparam int GUARD_BITS = 8;
  localparam int XW         = 27;  // x/y: 16-bit reading, 8 guard bits, gain and sign headroom
  localparam int ZW         = 26;  // angle accumulator, 1/65536 degree

  // CRC-8
  localparam logic [7:0] CRC_POLY = 8'h1D;
  localparam logic [7:0] CRC_INIT = 8'hFB;

  // angle constants
  localparam logic signed [ZW-1:0] DEG90_Z     = ZW'(5898240);
  localparam int                   ANGLE_LIMIT = 23040;
  localparam int                   ROUND_HALF  = 256;
  localparam int                   OUT_SHIFT   = 9;

  // work queue
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // status codes
  localparam logic [1:0] STAT_OK  = 2'd0;
  localparam logic [1:0] STAT_CRC = 2'd1;
  localparam logic [1:0] STAT_SAT = 2'd2;

  typedef struct packed {
    logic signed [15:0] x_raw;
    logic signed [15:0] y_raw;
    logic [7:0]         check_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [15:0] angle;
  } out_item_t;

  // classified, pre-rotated item handed from front to back
  typedef struct packed {
    logic [1:0]           status;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } work_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // one byte through the CRC register, MSB first
  function automatic logic [7:0] crc_byte(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] a;
    a = acc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (a[7]) begin
        a = {a[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        a = {a[6:0], 1'b0};
      end
    end
    return a;
  endfunction

  // atan(2^-i) in degrees * 65536, rounded
  function automatic logic signed [ZW-1:0] atan_tab(input int unsigned i);
    logic signed [31:0] t;
    case (i)
      0:       t = 32'sd2949120;
      1:       t = 32'sd1740967;
      2:       t = 32'sd919879;
      3:       t = 32'sd466945;
      4:       t = 32'sd234379;
      5:       t = 32'sd117304;
      6:       t = 32'sd58666;
      7:       t = 32'sd29335;
      8:       t = 32'sd14668;
      9:       t = 32'sd7334;
      10:      t = 32'sd3667;
      11:      t = 32'sd1833;
      12:      t = 32'sd917;
      13:      t = 32'sd458;
      14:      t = 32'sd229;
      15:      t = 32'sd115;
      16:      t = 32'sd57;
      17:      t = 32'sd29;
      18:      t = 32'sd14;
      19:      t = 32'sd7;
      20:      t = 32'sd4;
      21:      t = 32'sd2;
      22:      t = 32'sd1;
      default: t = 32'sd0;
    endcase
    return t[ZW-1:0];
  endfunction

endpackage

/* rtl/core/afc_front.sv */
// Front end: two-stage CRC check, reading classification and quadrant pre-rotation.
// Depends on afc_pkg; feeds afc_queue.
module afc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  afc_pkg::in_item_t in_data,
  input  afc_pkg::q_stat_t  q_stat,
  output logic              push,
  output afc_pkg::work_t    push_data
);

  logic              f0_v_r;
  afc_pkg::in_item_t f0_item_r;
  logic [7:0]        f0_crc_r;
  logic              f1_v_r;
  afc_pkg::work_t    f1_work_r;
  afc_pkg::work_t    f1_work_nxt;
  logic              adv;
  logic [7:0]        crc_x;
  logic [7:0]        crc_fin;
  logic              bad_x;
  logic              bad_y;
  logic signed [afc_pkg::XW-1:0] xs;
  logic signed [afc_pkg::XW-1:0] ys;

  // whole front moves together when its last stage can drain
  assign adv      = !f1_v_r || !q_stat.full;
  assign in_ready = adv;
  assign push     = f1_v_r && !q_stat.full;
  assign push_data = f1_work_r;

  // CRC over X bytes
  assign crc_x = afc_pkg::crc_byte(afc_pkg::crc_byte(afc_pkg::CRC_INIT, in_data.x_raw[7:0]),
                                   in_data.x_raw[15:8]);

  // CRC over Y bytes, inverted
  assign crc_fin = ~afc_pkg::crc_byte(afc_pkg::crc_byte(f0_crc_r, f0_item_r.y_raw[7:0]),
                                      f0_item_r.y_raw[15:8]);

  assign bad_x = (f0_item_r.x_raw == 16'sd0) || (f0_item_r.x_raw == 16'sh7FFF) ||
                 (f0_item_r.x_raw == 16'sh8000);
  assign bad_y = (f0_item_r.y_raw == 16'sd0) || (f0_item_r.y_raw == 16'sh7FFF) ||
                 (f0_item_r.y_raw == 16'sh8000);

  assign xs = {{(afc_pkg::XW-16-afc_pkg::GUARD_BITS){f0_item_r.x_raw[15]}},
               f0_item_r.x_raw, {afc_pkg::GUARD_BITS{1'b0}}};
  assign ys = {{(afc_pkg::XW-16-afc_pkg::GUARD_BITS){f0_item_r.y_raw[15]}},
               f0_item_r.y_raw, {afc_pkg::GUARD_BITS{1'b0}}};

  always_comb begin
    f1_work_nxt.status = afc_pkg::STAT_OK;
    f1_work_nxt.x      = xs;
    f1_work_nxt.y      = ys;
    f1_work_nxt.z      = '0;
    if (crc_fin != f0_item_r.check_byte) begin
      f1_work_nxt.status = afc_pkg::STAT_CRC;
    end else if (bad_x || bad_y) begin
      f1_work_nxt.status = afc_pkg::STAT_SAT;
    end
    // left half plane: rotate by -90 or +90 first
    if (xs < 0) begin
      if (ys >= 0) begin
        f1_work_nxt.x = ys;
        f1_work_nxt.y = -xs;
        f1_work_nxt.z = afc_pkg::DEG90_Z;
      end else begin
        f1_work_nxt.x = -ys;
        f1_work_nxt.y = xs;
        f1_work_nxt.z = -afc_pkg::DEG90_Z;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f0_v_r <= 1'b0;
      f1_v_r <= 1'b0;
    end else if (adv) begin
      f0_v_r <= in_valid;
      f1_v_r <= f0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f0_item_r <= in_data;
      f0_crc_r  <= crc_x;
      f1_work_r <= f1_work_nxt;
    end
  end

endmodule

/* rtl/core/afc_queue.sv */
// Short FIFO of classified work items between front and back.
// Depends on afc_pkg.
module afc_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  afc_pkg::work_t   push_data,
  input  logic             pop,
  output afc_pkg::work_t   head,
  output afc_pkg::q_stat_t q_stat
);

  afc_pkg::work_t          mem_r [afc_pkg::QDEPTH];
  logic [afc_pkg::QAW-1:0] wr_ptr_r;
  logic [afc_pkg::QAW-1:0] rd_ptr_r;
  logic [afc_pkg::QAW:0]   cnt_r;
  logic [afc_pkg::QAW:0]   cnt_nxt;

  assign head         = mem_r[rd_ptr_r];
  assign q_stat.full  = (cnt_r == (afc_pkg::QAW+1)'(afc_pkg::QDEPTH));
  assign q_stat.empty = (cnt_r == '0);

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* rtl/core/afc_cordic.sv */
// Back end: pipelined vectoring CORDIC, one iteration per stage, then rounding,
// saturation and the output register. Depends on afc_pkg; reads afc_queue.
module afc_cordic (
  input  logic               clk,
  input  logic               rst_n,
  input  afc_pkg::q_stat_t   q_stat,
  input  afc_pkg::work_t     head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output afc_pkg::out_item_t out_data
);

  localparam int N = afc_pkg::NSTEPS;

  logic [N-1:0]                  v_r;
  logic [1:0]                    st_r  [N];
  logic signed [afc_pkg::XW-1:0] x_r   [N];
  logic signed [afc_pkg::XW-1:0] y_r   [N];
  logic signed [afc_pkg::ZW-1:0] z_r   [N];
  logic signed [afc_pkg::XW-1:0] x_nxt [N];
  logic signed [afc_pkg::XW-1:0] y_nxt [N];
  logic signed [afc_pkg::ZW-1:0] z_nxt [N];
  logic [1:0]                    st_nxt [N];
  logic                          adv;
  logic                          out_v_r;
  afc_pkg::out_item_t            out_r;
  afc_pkg::out_item_t            out_nxt;
  logic signed [afc_pkg::ZW:0]   zr;
  logic signed [afc_pkg::ZW:0]   a;

  localparam logic signed [afc_pkg::ZW:0] A_MAX = (afc_pkg::ZW+1)'(afc_pkg::ANGLE_LIMIT);
  localparam logic signed [afc_pkg::ZW:0] A_MIN = -A_MAX;

  // pipeline advances as a whole whenever the output register is free or draining
  assign adv       = !out_v_r || out_ready;
  assign pop       = adv && !q_stat.empty;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  for (genvar i = 0; i < N; i++) begin : g_it
    logic signed [afc_pkg::XW-1:0] xi;
    logic signed [afc_pkg::XW-1:0] yi;
    logic signed [afc_pkg::ZW-1:0] zi;
    logic [1:0]                    si;
    if (i == 0) begin : g_first
      assign xi = head.x;
      assign yi = head.y;
      assign zi = head.z;
      assign si = head.status;
    end else begin : g_rest
      assign xi = x_r[i-1];
      assign yi = y_r[i-1];
      assign zi = z_r[i-1];
      assign si = st_r[i-1];
    end

    always_comb begin
      st_nxt[i] = si;
      if (yi >= 0) begin
        x_nxt[i] = xi + (yi >>> i);
        y_nxt[i] = yi - (xi >>> i);
        z_nxt[i] = zi + afc_pkg::atan_tab(i);
      end else begin
        x_nxt[i] = xi - (yi >>> i);
        y_nxt[i] = yi + (xi >>> i);
        z_nxt[i] = zi - afc_pkg::atan_tab(i);
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        x_r[i]  <= x_nxt[i];
        y_r[i]  <= y_nxt[i];
        z_r[i]  <= z_nxt[i];
        st_r[i] <= st_nxt[i];
      end
    end
  end

  // round half up to 1/128 degree, then clamp
  always_comb begin
    zr = {z_r[N-1][afc_pkg::ZW-1], z_r[N-1]} + (afc_pkg::ZW+1)'(afc_pkg::ROUND_HALF);
    a  = zr >>> afc_pkg::OUT_SHIFT;
    if (a > A_MAX) begin
      a = A_MAX;
    end else if (a < A_MIN) begin
      a = A_MIN;
    end
    out_nxt.status = st_r[N-1];
    out_nxt.angle  = (st_r[N-1] == afc_pkg::STAT_OK) ? a[15:0] : 16'sd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r     <= '0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      v_r     <= {v_r[N-2:0], pop};
      out_v_r <= v_r[N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
    end
  end

endmodule

/* rtl/core/angle_frame_check_atan2_core.sv */
// Angle frame check core: CRC-8 check of a sensor frame, then atan2(Y,X) by CORDIC.
// An accepted item passes front stages 0 and 1, the queue, the CORDIC stages and the output register.
// Throughput: one item per cycle; front, 4-entry queue and CORDIC pipeline each stall alone.
// The CORDIC pipeline, one iteration per stage, makes up most of that path.
// Reset (rst_n low, synchronous) empties the pipeline, queue and output register.
// Depends on afc_pkg, afc_front, afc_queue, afc_cordic.
module angle_frame_check_atan2_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  afc_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output afc_pkg::out_item_t out_data
);

  // front -> queue
  logic             push;
  afc_pkg::work_t   push_data;
  // queue -> back
  logic             pop;
  afc_pkg::work_t   head;
  afc_pkg::q_stat_t q_stat;

  // Front: stage 0 runs the CRC over the X bytes, stage 1 finishes over the Y bytes,
  // compares with the check byte, flags zero or rail readings and folds the left
  // half plane onto the right with a +/-90 degree start angle.
  afc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  // Queue decouples the front from output backpressure seen by the CORDIC.
  afc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  // Back: one CORDIC iteration per stage; rejected items ride along and come out
  // with their status and a zero angle.
  afc_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // rejected frames always carry a zero angle
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != afc_pkg::STAT_OK) |-> out_data.angle == 16'sd0)
    else $error("nonzero angle on rejected item");

  // angle stays within +/-180 degrees
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.angle <= 16'sd23040) && (out_data.angle >= -16'sd23040))
    else $error("angle out of range");

  // only the three defined status codes
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == afc_pkg::STAT_OK) ||
                  (out_data.status == afc_pkg::STAT_CRC) ||
                  (out_data.status == afc_pkg::STAT_SAT))
    else $error("undefined status code");

  // a stalled result item stays put until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

endmodule

/* test/angle_frame_check_atan2_core_tb.sv */
// Testbench for angle_frame_check_atan2_core: CRC-8 frame check followed by CORDIC atan2.
// Holds its own predictor in a small scoreboard class; depends on afc_pkg for the port types.
// Drives random valid/ready idling on both sides and one long output stall.
module angle_frame_check_atan2_core_tb;

  localparam int RANDOM_FRAMES  = 1230;
  localparam int WATCHDOG_LIMIT = 5000;  // cycles with no item moving on either side
  localparam int DRAIN_CYCLES   = 40;    // extra wait for stray results after the last expected one
  localparam int HOLD_AT_RESULT = 300;   // result count at which the long output hold starts
  localparam int HOLD_CYCLES    = 300;

  // reading values the block refuses to turn into an angle
  localparam logic [15:0] READ_ZERO = 16'h0000;
  localparam logic [15:0] READ_MAX  = 16'h7FFF;
  localparam logic [15:0] READ_MIN  = 16'h8000;

  // expected-result store plus the bit-exact angle predictor
  class angle_scoreboard;
    afc_pkg::out_item_t pending[$];
    int errors;
    int results_seen;
    // atan(2^-i) in 1/65536 degree, rounded
    longint atan_deg[24] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115,
      57, 29, 14, 7, 4, 2, 1, 0
    };

    // CRC-8, poly 0x1D, init 0xFB, inverted; X low, X high, Y low, Y high
    function logic [7:0] frame_crc(logic [15:0] xr, logic [15:0] yr);
      logic [7:0] acc;
      logic [31:0] bytes;
      acc = 8'hFB;
      bytes = {xr[7:0], xr[15:8], yr[7:0], yr[15:8]};
      for (int b = 0; b < 4; b++) begin
        acc = acc ^ bytes[31 - 8*b -: 8];
        for (int k = 0; k < 8; k++) begin
          if (acc[7]) begin
            acc = {acc[6:0], 1'b0} ^ 8'h1D;
          end else begin
            acc = {acc[6:0], 1'b0};
          end
        end
      end
      return ~acc;
    endfunction

    function bit unusable(logic [15:0] v);
      return v == READ_ZERO || v == READ_MAX || v == READ_MIN;
    endfunction

    function afc_pkg::out_item_t expected_angle(afc_pkg::in_item_t f);
      afc_pkg::out_item_t r;
      longint x, y, z, dx, dy, a, t;
      int steps;
      r.status = afc_pkg::STAT_OK;
      r.angle  = '0;
      if (frame_crc(f.x_raw, f.y_raw) != f.check_byte) begin
        r.status = afc_pkg::STAT_CRC;
        return r;
      end
      if (unusable(f.x_raw) || unusable(f.y_raw)) begin
        r.status = afc_pkg::STAT_SAT;
        return r;
      end
      x = longint'(f.x_raw) * 256;
      y = longint'(f.y_raw) * 256;
      z = 0;
      // left half plane: rotate by +/-90 degrees first
      if (x < 0) begin
        t = x;
        if (y >= 0) begin
          x = y;
          y = -t;
          z = 5898240;
        end else begin
          x = -y;
          y = t;
          z = -5898240;
        end
      end
      steps = (afc_pkg::CORDIC_STEPS > 24) ? 24 : afc_pkg::CORDIC_STEPS;
      for (int i = 0; i < steps; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x = x + dx;
          y = y - dy;
          z = z + atan_deg[i];
        end else begin
          x = x - dx;
          y = y + dy;
          z = z - atan_deg[i];
        end
      end
      a = (z + 256) >>> 9;
      if (a > 23040) a = 23040;
      if (a < -23040) a = -23040;
      r.angle = a[15:0];
      return r;
    endfunction

    function void note_frame(afc_pkg::in_item_t f);
      pending.push_back(expected_angle(f));
    endfunction

    function void check_result(afc_pkg::out_item_t got);
      afc_pkg::out_item_t want;
      results_seen++;
      if (pending.size() == 0) begin
        $display("%0t: result with nothing expected: status %0d angle %0d",
                 $time, got.status, got.angle);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status mismatch: expected %0d, actual %0d",
                 $time, want.status, got.status);
        errors++;
      end
      if (got.angle !== want.angle) begin
        $display("%0t: angle mismatch: expected %0d, actual %0d",
                 $time, want.angle, got.angle);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  afc_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_ready;
  afc_pkg::out_item_t out_data;

  angle_scoreboard sb;
  int idle_cycles;
  bit burst_mode;  // sender offers back to back, no gaps

  angle_frame_check_atan2_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
  end

  always #10 clk = ~clk;

  // mostly short gaps, a few long ones
  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // reading mix: full range, small magnitudes near the axes, edges, refused values
  function logic [15:0] pick_reading();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return 16'($urandom);
      6, 7:             return 16'($urandom_range(0, 128) - 64);
      8:                return $urandom_range(0, 1) ? 16'($urandom_range(32750, 32767))
                                                    : 16'(-$urandom_range(32750, 32768));
      default: begin
        case ($urandom_range(0, 2))
          0:       return READ_ZERO;
          1:       return READ_MAX;
          default: return READ_MIN;
        endcase
      end
    endcase
  endfunction

  // good_crc=0 corrupts the check byte by a nonzero pattern
  function afc_pkg::in_item_t build_frame(logic [15:0] xr, logic [15:0] yr, bit good_crc);
    afc_pkg::in_item_t f;
    logic [7:0] flip;
    flip = good_crc ? 8'h00 : 8'($urandom_range(1, 255));
    f.x_raw      = xr;
    f.y_raw      = yr;
    f.check_byte = sb.frame_crc(xr, yr) ^ flip;
    return f;
  endfunction

  // Offer one item at the falling edge and hold it until a rising edge takes it.
  task automatic send_frame(afc_pkg::in_item_t f);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= f;
    do @(posedge clk); while (!in_ready);
    sb.note_frame(f);
  endtask

  // Drop valid for a gap of length n; n=0 keeps the next item right behind.
  task automatic idle_sender(int n);
    if (n > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      in_data  <= afc_pkg::in_item_t'({$urandom, 8'($urandom)});
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic send_directed(logic [15:0] xr, logic [15:0] yr, bit good_crc);
    send_frame(build_frame(xr, yr, good_crc));
    idle_sender(burst_mode ? 0 : pick_gap());
  endtask

  // Result side: random stalls, calm stretches, and one long hold so the block
  // backs up through the pipeline and queue and drops in_ready.
  initial begin : receiver
    int stall_left;
    int mode_left;
    bit calm;
    bit hold_done;
    out_ready  = 1'b0;
    stall_left = 0;
    mode_left  = 0;
    calm       = 1'b0;
    hold_done  = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        calm      = ($urandom_range(0, 3) == 0);
        mode_left = $urandom_range(50, 200);
      end
      mode_left--;
      if (!hold_done && sb.results_seen >= HOLD_AT_RESULT) begin
        hold_done  = 1'b1;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < 30) begin
        stall_left = pick_gap();
        out_ready <= (stall_left == 0);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // compare every accepted result against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result(out_data);
    end
  end

  // watchdog: no item moving on either side for too long means a hang
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    sb          = new();
    burst_mode  = 1'b0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: refused readings on each axis, quadrant corners, near +/-180,
    // +/-90 and 0, extremes of the usable range, and CRC mismatches
    send_directed(16'sd32767,  16'sd1000,   1'b1);
    send_directed(-16'sd32768, 16'sd1000,   1'b1);
    send_directed(16'sd1000,   16'sd0,      1'b1);
    send_directed(16'sd0,      16'sd1000,   1'b1);
    send_directed(16'sd1000,   16'sd32767,  1'b1);
    send_directed(16'sd1000,   -16'sd32768, 1'b1);
    send_directed(16'sd0,      16'sd0,      1'b1);
    send_directed(16'sd1,      16'sd1,      1'b1);
    send_directed(-16'sd1,     16'sd1,      1'b1);
    send_directed(-16'sd1,     -16'sd1,     1'b1);
    send_directed(16'sd1,      -16'sd1,     1'b1);
    send_directed(-16'sd32767, 16'sd1,      1'b1);
    send_directed(-16'sd32767, -16'sd1,     1'b1);
    send_directed(16'sd32766,  16'sd1,      1'b1);
    send_directed(16'sd32766,  -16'sd1,     1'b1);
    send_directed(16'sd1,      16'sd32766,  1'b1);
    send_directed(16'sd1,      -16'sd32767, 1'b1);
    send_directed(16'sd32766,  16'sd32766,  1'b1);
    send_directed(-16'sd32767, -16'sd32767, 1'b1);
    send_directed(-16'sd32767, 16'sd32766,  1'b1);
    send_directed(16'sd1234,   -16'sd4321,  1'b0);
    send_directed(16'sd0,      -16'sd32768, 1'b0);
    send_directed(16'hFFFF,    16'hFFFF,    1'b0);

    // random: mostly frames with a correct check byte so the CORDIC path is
    // exercised; the rest carry a corrupted check byte
    for (int n = 0; n < RANDOM_FRAMES; n++) begin
      if (n % 100 == 0) begin
        burst_mode = ($urandom_range(0, 2) == 0);
      end
      send_directed(pick_reading(), pick_reading(), $urandom_range(0, 99) < 82);
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    // stray results after the last expected one still count as failures
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/afc_pkg.sv
rtl/core/afc_front.sv
rtl/core/afc_queue.sv
rtl/core/afc_cordic.sv
rtl/core/angle_frame_check_atan2_core.sv
test/angle_frame_check_atan2_core_tb.sv
